// File: sv/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
// No dependencies; used by sfr_parser and serial_frame_receiver.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int BUFFER_LEN_DEFAULT = 64;

  localparam logic [7:0] DELIM_RESET = 8'd126;

  localparam int ADDR_W = 3;
  localparam logic REG_START_DELIM = 1'b0;

  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_HEADER  = 3'd1;
  localparam logic [2:0] ST_PAYLOAD = 3'd2;
  localparam logic [2:0] ST_GOOD    = 3'd3;
  localparam logic [2:0] ST_BAD     = 3'd4;

  typedef struct packed {
    logic [6:0]  frame_length;
    logic [15:0] frame_command;
    logic [5:0]  payload_index;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
  } result_t;

endpackage

// File: sv/sfr_parser.sv
// Frame parser: phase machine, length/command capture and running checksum.
// Produces one result per byte. Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_parser #(
  parameter int BUFFER_LEN = sfr_pkg::BUFFER_LEN_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       start_delimiter,
  output sfr_pkg::result_t result
);

  localparam int LEN_W = $clog2(BUFFER_LEN + 1);
  localparam logic [15:0] BUF_LEN16 = 16'(BUFFER_LEN);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(BUFFER_LEN);

  typedef enum logic [2:0] {
    IDLE, LEN_HI, LEN_LO, CMD_HI, CMD_LO, DATA, CHECK
  } phase_t;

  phase_t           phase, phase_next;
  logic [7:0]       len_hi, len_hi_next;
  logic [LEN_W-1:0] length_reg, length_next;
  logic [15:0]      command_reg, command_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [2:0]       status;
  logic [7:0]       pbyte;
  logic [31:0]      pindex_ext;
  logic [31:0]      len_ext;

  function automatic logic [LEN_W-1:0] clamp(input logic [15:0] v);
    logic [LEN_W-1:0] r;
    r = (v >= BUF_LEN16) ? LEN_MAX : v[LEN_W-1:0];
    return r;
  endfunction

  always_comb begin
    phase_next       = phase;
    len_hi_next      = len_hi;
    length_next      = length_reg;
    command_next     = command_reg;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    status           = sfr_pkg::ST_IGNORED;
    pbyte            = 8'd0;
    pindex_ext       = 32'd0;
    if (rx_byte == start_delimiter) begin
      phase_next       = LEN_HI;
      len_hi_next      = 8'd0;
      length_next      = '0;
      command_next     = 16'd0;
      byte_count_next  = '0;
      running_sum_next = 8'd0;
      status           = sfr_pkg::ST_HEADER;
    end else begin
      unique case (phase)
        LEN_HI: begin
          len_hi_next      = rx_byte;
          length_next      = clamp({rx_byte, 8'h00});
          running_sum_next = running_sum + rx_byte;
          phase_next       = LEN_LO;
          status           = sfr_pkg::ST_HEADER;
        end
        LEN_LO: begin
          length_next      = clamp({len_hi, rx_byte});
          running_sum_next = running_sum + rx_byte;
          phase_next       = CMD_HI;
          status           = sfr_pkg::ST_HEADER;
        end
        CMD_HI: begin
          command_next     = {rx_byte, 8'h00};
          running_sum_next = running_sum + rx_byte;
          phase_next       = CMD_LO;
          status           = sfr_pkg::ST_HEADER;
        end
        CMD_LO: begin
          command_next     = {command_reg[15:8], rx_byte};
          running_sum_next = running_sum + rx_byte;
          byte_count_next  = '0;
          phase_next       = (length_reg == '0) ? CHECK : DATA;
          status           = sfr_pkg::ST_HEADER;
        end
        DATA: begin
          pbyte            = rx_byte;
          pindex_ext       = 32'(byte_count);
          running_sum_next = running_sum + rx_byte;
          byte_count_next  = byte_count + 1'b1;
          if (byte_count_next >= length_reg) begin
            phase_next = CHECK;
          end
          status           = sfr_pkg::ST_PAYLOAD;
        end
        CHECK: begin
          status     = (~running_sum == rx_byte) ? sfr_pkg::ST_GOOD : sfr_pkg::ST_BAD;
          phase_next = IDLE;
        end
        default: begin
          status = sfr_pkg::ST_IGNORED;
        end
      endcase
    end
  end

  assign len_ext = 32'(length_next);

  always_comb begin
    result.status        = status;
    result.payload_byte  = pbyte;
    result.payload_index = pindex_ext[5:0];
    result.frame_command = command_next;
    result.frame_length  = len_ext[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= IDLE;
      len_hi      <= 8'd0;
      length_reg  <= '0;
      command_reg <= 16'd0;
      byte_count  <= '0;
      running_sum <= 8'd0;
    end else if (advance) begin
      phase       <= phase_next;
      len_hi      <= len_hi_next;
      length_reg  <= length_next;
      command_reg <= command_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

// File: sv/serial_frame_receiver.sv
// Delimited serial frame receiver: register port, parser and output skid stage.
// Depends on sfr_pkg and sfr_parser.
// A result is registered in the output register, or in the skid register while
// the master side stalls. Throughput: one byte per cycle while the skid register
// is empty; both registers keep s_tready registered and independent of m_tready.
// Reset (rst, synchronous): parser idle, start delimiter 126, output stage empty.
`timescale 1ns / 1ps

module serial_frame_receiver #(
  parameter int BUFFER_LEN = sfr_pkg::BUFFER_LEN_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // rx_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // status[2:0], payload_byte[10:3], payload_index[16:11],
  // frame_command[32:17], frame_length[39:33]
  output logic [39:0]                m_tdata
);

  logic             [7:0] start_delimiter;
  logic                   in_xfer;
  sfr_pkg::result_t       result;
  sfr_pkg::result_t       out_reg;
  sfr_pkg::result_t       skid_reg;
  logic                   out_valid;
  logic                   skid_valid;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delimiter <= sfr_pkg::DELIM_RESET;
    end else if (psel && penable && pwrite && paddr[2] == sfr_pkg::REG_START_DELIM) begin
      start_delimiter <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == sfr_pkg::REG_START_DELIM) ? {24'd0, start_delimiter} : 32'd0;

  assign s_tready = !skid_valid;
  assign in_xfer  = s_tvalid && s_tready;

  sfr_parser #(
    .BUFFER_LEN(BUFFER_LEN)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .advance        (in_xfer),
    .rx_byte        (s_tdata),
    .start_delimiter(start_delimiter),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (m_tready) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end
      end else if (in_xfer) begin
        if (out_valid && !m_tready) begin
          skid_reg   <= result;
          skid_valid <= 1'b1;
        end else begin
          out_reg   <= result;
          out_valid <= 1'b1;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg;

endmodule

// File: tb/serial_frame_receiver_tb.sv
// Self-checking testbench for serial_frame_receiver: directed byte table, then random
// frames under several start delimiters, checked against an in-bench frame parser model.
// Depends on sfr_pkg and the serial_frame_receiver RTL.
`timescale 1ns / 1ps

module serial_frame_receiver_tb;

  localparam int FRAME_BUF = sfr_pkg::BUFFER_LEN_DEFAULT;
  localparam logic [sfr_pkg::ADDR_W-1:0] DELIM_ADDR = {sfr_pkg::REG_START_DELIM, 2'b00};
  localparam int DIR_ROWS = 25;
  localparam int LONG_HOLD = 200;

  typedef enum logic [2:0] {
    WAIT_DELIM, GET_LEN_HI, GET_LEN_LO, GET_CMD_HI, GET_CMD_LO, GET_DATA, GET_SUM
  } parse_phase_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    logic [2:0]  st;
    logic [15:0] cmd;
    logic [6:0]  len;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [sfr_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // rx_byte
  logic        m_tvalid;
  logic        m_tready;
  // status[2:0], payload_byte[10:3], payload_index[16:11],
  // frame_command[32:17], frame_length[39:33]
  logic [39:0] m_tdata;

  serial_frame_receiver u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // parser model state
  parse_phase_t cur_phase;
  logic [7:0]   delim_q;
  logic [15:0]  len_q;
  logic [15:0]  cmd_q;
  logic [6:0]   cnt_q;
  logic [7:0]   sum_q;

  sfr_pkg::result_t pending_results[$];
  dir_row_t         dir_table[DIR_ROWS];
  int               err_count;
  int               shown_count;
  bit               src_steady;
  bit               sink_steady;
  bit               hold_off_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic sfr_pkg::result_t parse_byte(input logic [7:0] b);
    sfr_pkg::result_t r;
    logic [15:0]      shown;
    r = '0;
    r.status = sfr_pkg::ST_IGNORED;
    if (b == delim_q) begin
      len_q = '0;
      cmd_q = '0;
      cnt_q = '0;
      sum_q = '0;
      cur_phase = GET_LEN_HI;
      r.status = sfr_pkg::ST_HEADER;
    end else begin
      case (cur_phase)
        GET_LEN_HI: begin
          len_q = {b, 8'h00};
          sum_q = sum_q + b;
          cur_phase = GET_LEN_LO;
          r.status = sfr_pkg::ST_HEADER;
        end
        GET_LEN_LO: begin
          len_q = len_q | {8'h00, b};
          if (len_q >= 16'(FRAME_BUF)) len_q = 16'(FRAME_BUF);
          sum_q = sum_q + b;
          cur_phase = GET_CMD_HI;
          r.status = sfr_pkg::ST_HEADER;
        end
        GET_CMD_HI: begin
          cmd_q = {b, 8'h00};
          sum_q = sum_q + b;
          cur_phase = GET_CMD_LO;
          r.status = sfr_pkg::ST_HEADER;
        end
        GET_CMD_LO: begin
          cmd_q = cmd_q | {8'h00, b};
          sum_q = sum_q + b;
          cnt_q = '0;
          cur_phase = (len_q == 16'd0) ? GET_SUM : GET_DATA;
          r.status = sfr_pkg::ST_HEADER;
        end
        GET_DATA: begin
          r.payload_byte = b;
          r.payload_index = cnt_q[5:0];
          sum_q = sum_q + b;
          cnt_q = cnt_q + 7'd1;
          if (16'(cnt_q) >= len_q) cur_phase = GET_SUM;
          r.status = sfr_pkg::ST_PAYLOAD;
        end
        GET_SUM: begin
          r.status = (~sum_q == b) ? sfr_pkg::ST_GOOD : sfr_pkg::ST_BAD;
          cur_phase = WAIT_DELIM;
        end
        default: r.status = sfr_pkg::ST_IGNORED;
      endcase
    end
    shown = (len_q > 16'(FRAME_BUF)) ? 16'(FRAME_BUF) : len_q;
    r.frame_command = cmd_q;
    r.frame_length = shown[6:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    err_count++;
    if (shown_count < 10) begin
      shown_count++;
      $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) report_mismatch(what, want, got);
  endtask

  // result side checker
  always @(posedge clk) begin
    sfr_pkg::result_t got;
    sfr_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = sfr_pkg::result_t'(m_tdata);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transfer", 32'h0, 32'(m_tdata[31:0]));
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
        compare_field("payload_index", 32'(want.payload_index), 32'(got.payload_index));
        compare_field("frame_command", 32'(want.frame_command), 32'(got.frame_command));
        compare_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
      end
    end
  end

  // result side flow control
  initial begin
    int stall;
    m_tready = 1'b0;
    sink_steady = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 14);
      for (int i = 0; i < stall; i++) begin
        m_tready = 1'b0;
        @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input sfr_pkg::result_t want);
    int gap;
    if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 14);
    for (int i = 0; i < gap; i++) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = b;
    do @(posedge clk); while (!s_tready);
    want = typed ? want : parse_byte(b);
    if (typed) void'(parse_byte(b));
    pending_results.push_back(want);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = DELIM_ADDR;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_delimiter(input logic [7:0] value);
    logic [31:0] rd;
    repeat (4) @(posedge clk);
    apb_access(1'b1, {24'($urandom_range(0, 24'hFFFFFF)), value}, rd);
    delim_q = value;
    apb_access(1'b0, 32'h0, rd);
    compare_field("start_delimiter readback", 32'(value), rd);
  endtask

  function automatic logic [7:0] keep_body(input logic [7:0] b);
    // mostly keep the delimiter out of the frame body
    if (b == delim_q && $urandom_range(0, 9) != 0) return b ^ 8'h01;
    return b;
  endfunction

  task automatic send_frames(input int n_items);
    logic [7:0]  fb[$];
    logic [15:0] flen;
    logic [7:0]  acc;
    int          npay;
    int          sent;
    int          pick;
    sent = 0;
    while (sent < n_items) begin
      fb.delete();
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 19))
          0:       flen = 16'($urandom_range(0, 16'hFFFF));
          1:       flen = 16'(FRAME_BUF);
          2:       flen = 16'($urandom_range(9, FRAME_BUF - 1));
          default: flen = 16'($urandom_range(0, 8));
        endcase
        flen = {keep_body(flen[15:8]), keep_body(flen[7:0])};
        npay = (flen >= 16'(FRAME_BUF)) ? FRAME_BUF : int'(flen);
        fb.push_back(delim_q);
        fb.push_back(flen[15:8]);
        fb.push_back(flen[7:0]);
        fb.push_back(keep_body(8'($urandom_range(0, 255))));
        fb.push_back(keep_body(8'($urandom_range(0, 255))));
        repeat (npay) fb.push_back(keep_body(8'($urandom_range(0, 255))));
        acc = '0;
        for (int i = 1; i < fb.size(); i++) acc = acc + fb[i];
        acc = ~acc;
        if ($urandom_range(0, 4) == 0) acc = acc ^ 8'($urandom_range(1, 255));
        fb.push_back(acc);
        // cut the frame short
        if (pick == 1) fb = fb[0:$urandom_range(0, fb.size() - 2)];
      end
      foreach (fb[i]) send_byte(fb[i], 1'b0, '0);
      sent += fb.size();
    end
  endtask

  initial begin
    sfr_pkg::result_t want;
    logic [31:0]      rd;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    err_count = 0;
    shown_count = 0;
    src_steady = 1'b0;
    hold_off_req = 1'b0;
    cur_phase = WAIT_DELIM;
    delim_q = sfr_pkg::DELIM_RESET;
    len_q = '0;
    cmd_q = '0;
    cnt_q = '0;
    sum_q = '0;

    dir_table = '{
      '{8'h00,                 1'b1, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'hFF,                 1'b1, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{sfr_pkg::DELIM_RESET,  1'b1, sfr_pkg::ST_HEADER,  16'h0000, 7'd0},
      '{8'h00,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'h03,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'hAB,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'hCD,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'h00,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'hFF,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'h55,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'h30,                 1'b1, sfr_pkg::ST_GOOD,    16'hABCD, 7'd3},
      '{8'h30,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{sfr_pkg::DELIM_RESET,  1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'hFF,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'hFF,                 1'b1, sfr_pkg::ST_HEADER,  16'h0000, 7'd64},
      '{8'h00,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{sfr_pkg::DELIM_RESET,  1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'h00,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'h00,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'h12,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'h34,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'h00,                 1'b1, sfr_pkg::ST_BAD,     16'h1234, 7'd0},
      '{sfr_pkg::DELIM_RESET,  1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'h00,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0},
      '{8'h40,                 1'b0, sfr_pkg::ST_IGNORED, 16'h0000, 7'd0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    apb_access(1'b0, 32'h0, rd);
    compare_field("start_delimiter after reset", 32'(sfr_pkg::DELIM_RESET), rd);

    foreach (dir_table[i]) begin
      want = '0;
      want.status = dir_table[i].st;
      want.frame_command = dir_table[i].cmd;
      want.frame_length = dir_table[i].len;
      send_byte(dir_table[i].rx, dir_table[i].typed, want);
    end
    drain();

    set_delimiter(8'h00);
    send_frames(150);
    hold_off_req = 1'b1;
    send_frames(150);
    drain();

    set_delimiter(8'hFF);
    send_frames(150);
    drain();
    send_frames(150);
    drain();

    set_delimiter(8'($urandom_range(1, 254)));
    send_frames(300);
    drain();

    set_delimiter(8'($urandom_range(0, 255)));
    send_frames(300);
    drain();

    set_delimiter(sfr_pkg::DELIM_RESET);
    send_frames(300);
    drain();

    repeat (8) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
sv/sfr_pkg.sv
sv/sfr_parser.sv
sv/serial_frame_receiver.sv
tb/serial_frame_receiver_tb.sv
